// ----- rtl/bbru_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the bitplane ByteRun1 unpacker.
// Used by every module in this folder; depends on nothing else.
package bbru_pkg;

    // Address width default and clamps on the picture geometry.
    localparam int ADDR_BITS_DEF = 24;
    localparam int MAX_LINES     = 4096;
    localparam int MAX_PLANES    = 8;

    // Field widths fixed by the interface.
    localparam int OUT_ADDR_W = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int ROW_POS_W  = 16;
    localparam int ROW_BYTES_W = 12;

    // Register reset values.
    localparam logic [13:0] PIXEL_WIDTH_RST  = 14'd320;
    localparam logic [12:0] PIXEL_HEIGHT_RST = 13'd200;
    localparam logic [3:0]  PLANE_COUNT_RST  = 4'd5;
    localparam logic [12:0] ROW_STRIDE_RST   = 13'd48;
    localparam logic [23:0] DEST_BASE_RST    = 24'd0;

    // Control byte that encodes no operation (-128).
    localparam logic [7:0] CTRL_NOP = 8'h80;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_WIDTH  = 3'd0,
        CFG_PIXEL_HEIGHT = 3'd1,
        CFG_PLANE_COUNT  = 3'd2,
        CFG_COMP_MODE    = 3'd3,
        CFG_ROW_STRIDE   = 3'd4,
        CFG_DEST_BASE    = 3'd5
    } t_cfg_idx;

    // Compression modes; the remaining codes ignore the body.
    typedef enum logic [1:0] {
        MODE_RAW      = 2'd0,
        MODE_BYTERUN1 = 2'd1
    } t_mode;

    // Decoder phase, one-hot.
    typedef enum logic [2:0] {
        PH_CONTROL = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } t_phase;

    // Input beat.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       frame_start;
    } t_in_beat;

    // Output beat: one memory fill command.
    typedef struct packed {
        logic [OUT_ADDR_W-1:0] write_addr;
        logic [7:0]            write_value;
        logic [7:0]            write_count;
        logic                  frame_last;
    } t_out_beat;

    // Geometry and mode as the decoder sees them.
    typedef struct packed {
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [3:0]             eff_planes;
        logic [12:0]            eff_lines;
        logic                   empty;
        t_mode                  mode;
        logic [12:0]            row_stride;
        logic [23:0]            dest_base;
    } t_cfg;

    // Write of the base register, seen by the decoder.
    typedef struct packed {
        logic        load;
        logic [23:0] value;
    } t_base_load;

endpackage

// ----- rtl/bbru_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration registers and the geometry derived from them.
// Depends on bbru_pkg.
module bbru_cfg_regs
    import bbru_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg,
    output t_base_load           o_base_load
);

    logic [13:0] r_pixel_width;
    logic [12:0] r_pixel_height;
    logic [3:0]  r_plane_count;
    t_mode       r_mode;
    logic [12:0] r_row_stride;
    logic [23:0] r_dest_base;

    logic        cfg_wr;
    logic [14:0] pw_sum;
    logic [16:0] height_ext;

    // Writes are taken only while no beat waits in the input register.
    assign o_cfg_ready = !i_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Register file; writes beyond the last index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_width  <= PIXEL_WIDTH_RST;
            r_pixel_height <= PIXEL_HEIGHT_RST;
            r_plane_count  <= PLANE_COUNT_RST;
            r_mode         <= MODE_BYTERUN1;
            r_row_stride   <= ROW_STRIDE_RST;
            r_dest_base    <= DEST_BASE_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_WIDTH:  r_pixel_width  <= i_cfg_data[13:0];
                CFG_PIXEL_HEIGHT: r_pixel_height <= i_cfg_data[12:0];
                CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[3:0];
                CFG_COMP_MODE:    r_mode         <= t_mode'(i_cfg_data[1:0]);
                CFG_ROW_STRIDE:   r_row_stride   <= i_cfg_data[12:0];
                CFG_DEST_BASE:    r_dest_base    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // A base write may also move the current row base at the frame origin.
    assign o_base_load.load  = cfg_wr && (t_cfg_idx'(i_cfg_index) == CFG_DEST_BASE);
    assign o_base_load.value = i_cfg_data[23:0];

    // Row byte count is the width rounded up to whole 16-pixel words, in bytes.
    assign pw_sum     = {1'b0, r_pixel_width} + 15'd15;
    assign height_ext = {4'd0, r_pixel_height};

    always_comb begin
        o_cfg.row_bytes  = {pw_sum[14:4], 1'b0};
        o_cfg.eff_planes = (r_plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : r_plane_count;
        o_cfg.eff_lines  = (height_ext > 17'(MAX_LINES)) ? 13'(MAX_LINES) : r_pixel_height;
        o_cfg.empty      = (o_cfg.row_bytes == '0) || (o_cfg.eff_planes == '0) ||
                           (o_cfg.eff_lines == '0);
        o_cfg.mode       = r_mode;
        o_cfg.row_stride = r_row_stride;
        o_cfg.dest_base  = r_dest_base;
    end

endmodule

// ----- rtl/bbru_decode.sv -----
`timescale 1ns / 1ps
// Decoder state and the single-pass step that turns one body byte into a fill.
// Depends on bbru_pkg.
module bbru_decode
    import bbru_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_in_beat   i_item,
    input  t_cfg       i_cfg,
    input  t_base_load i_base_load,
    output logic       o_res_valid,
    output t_out_beat  o_res
);

    localparam int ADDR_EXT_W = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

    t_phase                 r_phase, n_phase;
    logic [7:0]             r_run, n_run;
    logic [ROW_POS_W-1:0]   r_pos, n_pos;
    logic [3:0]             r_plane, n_plane;
    logic [12:0]            r_line, n_line;
    logic [ADDR_BITS-1:0]   r_base, n_base;
    logic                   r_done, n_done;

    // State after an optional frame start clear.
    t_phase                 c_phase;
    logic [7:0]             c_run;
    logic [ROW_POS_W-1:0]   c_pos;
    logic [3:0]             c_plane;
    logic [12:0]            c_line;
    logic [ADDR_BITS-1:0]   c_base;
    logic                   c_done;

    logic                   emit_en;
    logic                   check_en;
    logic [7:0]             emit_count;
    logic [ADDR_BITS-1:0]   emit_addr;
    logic [ADDR_EXT_W-1:0]  addr_ext;
    logic [ROW_POS_W-1:0]   pos_sum;
    logic                   row_full;
    logic [4:0]             plane_inc;
    logic [13:0]            line_inc;
    logic                   at_origin;

    // Frame start resets the position before the byte is used.
    always_comb begin
        if (i_item.frame_start) begin
            c_phase = PH_CONTROL;
            c_run   = '0;
            c_pos   = '0;
            c_plane = '0;
            c_line  = '0;
            c_base  = ADDR_BITS'(i_cfg.dest_base);
            c_done  = 1'b0;
        end else begin
            c_phase = r_phase;
            c_run   = r_run;
            c_pos   = r_pos;
            c_plane = r_plane;
            c_line  = r_line;
            c_base  = r_base;
            c_done  = r_done;
        end
    end

    // Shared fill datapath: address, new position and row end test.
    assign emit_addr = c_base + ADDR_BITS'(c_pos);
    assign addr_ext  = ADDR_EXT_W'(emit_addr);
    assign pos_sum   = c_pos + ROW_POS_W'(emit_count);
    assign row_full  = pos_sum >= ROW_POS_W'(i_cfg.row_bytes);
    assign plane_inc = {1'b0, c_plane} + 5'd1;
    assign line_inc  = {1'b0, c_line} + 14'd1;
    assign at_origin = !r_done && (r_line == '0) && (r_plane == '0) && (r_pos == '0) &&
                       (r_phase == PH_CONTROL);

    // Phase decode for one byte.
    always_comb begin
        n_phase    = c_phase;
        n_run      = c_run;
        emit_en    = 1'b0;
        check_en   = 1'b0;
        emit_count = 8'd1;
        if (!c_done && !i_cfg.empty) begin
            unique case (i_cfg.mode)
                MODE_RAW: begin
                    n_phase  = PH_CONTROL;
                    n_run    = '0;
                    emit_en  = 1'b1;
                    check_en = 1'b1;
                end
                MODE_BYTERUN1: begin
                    unique case (c_phase)
                        PH_LITERAL: begin
                            emit_en = 1'b1;
                            n_run   = c_run - 8'd1;
                            if (c_run == 8'd1) begin
                                n_phase  = PH_CONTROL;
                                check_en = 1'b1;
                            end
                        end
                        PH_REPEAT: begin
                            emit_en    = 1'b1;
                            emit_count = c_run;
                            n_run      = '0;
                            n_phase    = PH_CONTROL;
                            check_en   = 1'b1;
                        end
                        default: begin
                            if (i_item.body_byte == CTRL_NOP) begin
                                n_phase = PH_CONTROL;
                            end else if (!i_item.body_byte[7]) begin
                                n_run   = i_item.body_byte + 8'd1;
                                n_phase = PH_LITERAL;
                            end else begin
                                n_run   = 8'(9'd257 - {1'b0, i_item.body_byte});
                                n_phase = PH_REPEAT;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Position, row, plane and line advance plus the result beat.
    always_comb begin
        n_pos   = c_pos;
        n_plane = c_plane;
        n_line  = c_line;
        n_base  = c_base;
        n_done  = c_done;
        o_res_valid       = i_fire && emit_en;
        o_res.write_addr  = addr_ext[OUT_ADDR_W-1:0];
        o_res.write_value = i_item.body_byte;
        o_res.write_count = emit_count;
        o_res.frame_last  = 1'b0;
        if (emit_en) begin
            n_pos = pos_sum;
            if (check_en && row_full) begin
                n_pos  = '0;
                n_base = c_base + ADDR_BITS'(i_cfg.row_stride);
                if (plane_inc >= {1'b0, i_cfg.eff_planes}) begin
                    n_plane = '0;
                    n_line  = line_inc[12:0];
                    if (line_inc >= {1'b0, i_cfg.eff_lines}) begin
                        n_done           = 1'b1;
                        o_res.frame_last = 1'b1;
                    end
                end else begin
                    n_plane = plane_inc[3:0];
                end
            end
        end
    end

    // State registers; a base write at the frame origin reloads the row base.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CONTROL;
            r_run   <= '0;
            r_pos   <= '0;
            r_plane <= '0;
            r_line  <= '0;
            r_base  <= ADDR_BITS'(DEST_BASE_RST);
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_pos   <= n_pos;
            r_plane <= n_plane;
            r_line  <= n_line;
            r_base  <= n_base;
            r_done  <= n_done;
        end else if (i_base_load.load && at_origin) begin
            r_base <= ADDR_BITS'(i_base_load.value);
        end
    end

`ifndef ASSERT_OFF
    // A fill always covers 1 to 128 bytes.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.write_count != 8'd0) && (o_res.write_count <= 8'd128))
        else $error("fill count out of range");

    // The fill that completes the picture marks the frame as done.
    a_last_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.frame_last |=> r_done)
        else $error("frame not marked done after last fill");

    // A finished frame yields nothing until the next frame start.
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_done && !i_item.frame_start |-> !o_res_valid)
        else $error("fill produced after frame end");
`endif

endmodule

// ----- rtl/bbru_out_reg.sv -----
`timescale 1ns / 1ps
// Result register that holds a fill while the receiver stalls.
// Depends on bbru_pkg.
module bbru_out_reg
    import bbru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_res_valid,
    input  t_out_beat i_res,
    input  logic      i_out_stall,
    output logic      o_free,
    output logic      o_out_valid,
    output t_out_beat o_out_data
);

    logic      r_valid;
    t_out_beat r_data;

    // The register can load when empty or when its beat leaves this cycle.
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload loads only with a new fill.
    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ----- rtl/bitplane_byterun1_unpacker_unit.sv -----
`timescale 1ns / 1ps
// Top level of the bitplane ByteRun1 unpacker: input register and stage wiring.
// Depends on bbru_pkg, bbru_cfg_regs, bbru_decode and bbru_out_reg.
//
// Usage:
// The body of an interleaved-bitplane picture enters one byte per beat on the
// input channel (i_in_valid, o_in_stall, i_in_data). Each byte yields zero or
// one memory fill command on the output channel (o_out_valid, i_out_stall,
// o_out_data): a start address, a byte value and a repeat count of 1 to 128,
// with frame_last set on the fill that completes the final row.
// Configuration registers are written through i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data, while no byte is in flight.
// A byte accepted into the input register is decoded when it fires, and its
// fill is loaded into the result register, from which it is offered.
// Throughput: one byte per cycle while the receiver does not stall; the only
// loop is the decoder state update between the input and result registers.
// Reset clears the decoder to the frame origin and loads the register reset
// values. When the receiver stalls, the pending fill holds, one more byte waits
// in the input register, and o_in_stall rises in the same cycle.
module bitplane_byterun1_unpacker_unit
    import bbru_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_beat   r_in_data;
    logic       in_accept;
    logic       fire;
    logic       out_free;
    logic       res_valid;
    t_out_beat  res;
    t_cfg       cfg;
    t_base_load base_load;

    // The decoder step runs whenever a byte waits and the result slot is free.
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    bbru_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_busy      (r_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_base_load (base_load)
    );

    bbru_decode #(
        .ADDR_BITS (ADDR_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_data),
        .i_cfg       (cfg),
        .i_base_load (base_load),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bbru_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // An accepted byte is held in the input register for the next cycle.
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted byte lost from input register");
`endif

endmodule
